>>> hw/rtl/vilri_pkg.sv
// Shared types, constants and helpers for the virtual interrupt list-register injector.
`default_nettype none

package vilri_pkg;

    localparam int MAX_ENTRIES_DEF = 64;

    localparam int KIND_W  = 2;
    localparam int ID_W    = 10;
    localparam int INDEX_W = 6;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int WORD_W  = 32;
    localparam int NUM_W   = 7;

    localparam logic [NUM_W-1:0] NUM_ENTRIES_RST = 7'd64;

    localparam int PEND_BIT   = 28;
    localparam int HW_BIT     = 31;
    localparam int PHYS_SHIFT = 10;

    typedef enum logic [KIND_W-1:0] {
        K_INJECT = 2'd0,
        K_RETIRE = 2'd1,
        K_CLEAR  = 2'd2,
        K_NONE   = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_FULL    = 2'd2,
        ST_BADIDX  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    // Build the list word: virtual id, pending, and for non-SGI ids the hw bit and physical id.
    function automatic logic [WORD_W-1:0] make_word(input logic [ID_W-1:0] id);
        logic [WORD_W-1:0] w;
        w = '0;
        w[ID_W-1:0] = id;
        w[PEND_BIT] = 1'b1;
        if (|id[ID_W-1:4]) begin
            w[HW_BIT] = 1'b1;
            w[PHYS_SHIFT +: ID_W] = id;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/vilri_in_if.sv
// Request channel interface: valid/ready handshake with the request fields.
`default_nettype none

interface vilri_in_if
    import vilri_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    irq_id;
    logic [INDEX_W-1:0] entry_index;

    modport source (output valid, kind, irq_id, entry_index, input ready);
    modport sink   (input valid, kind, irq_id, entry_index, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/vilri_out_if.sv
// Result channel interface: valid/ready handshake with the result fields.
`default_nettype none

interface vilri_out_if
    import vilri_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] entry_word;

    modport source (output valid, status, slot, entry_word, input ready);
    modport sink   (input valid, status, slot, entry_word, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/virtual_irq_list_register_injector_top.sv
// Virtual interrupt list-register injector: entry table, scan sequencer and result register.
// Inject: scans entries 0..n-1 for the id and for a free entry, n the effective entry count (1..MAX_ENTRIES);
//   one entry is read from the word memory and checked by the single id comparator per cycle.
// Retire, clear and unknown kinds skip the scan; each result is loaded once the result register is free.
// A new request is taken in the cycle after the result is loaded.
// Synchronous active-low reset: all entries empty, entry count 64; word memory is not cleared.
`default_nettype none

module virtual_irq_list_register_injector_top
    import vilri_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cfg_we,
    input  wire [NUM_W-1:0] i_cfg_wdata,
    vilri_in_if.sink        i_in_ch,
    vilri_out_if.source     o_out_ch
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [NUM_W-1:0] MAX_NUM = NUM_W'(MAX_ENTRIES);

    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [ID_W-1:0]    r_id, n_id;
    logic [INDEX_W-1:0] r_idx_in, n_idx_in;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_cmp_vld, n_cmp_vld;
    logic               r_dup, n_dup;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_free_at, n_free_at;
    logic [MAX_ENTRIES-1:0] r_empty, n_empty;
    logic [NUM_W-1:0]   r_num;

    logic               r_out_vld, n_out_vld;
    t_status            r_status, n_status;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [WORD_W-1:0]  r_word, n_word;

    logic [WORD_W-1:0]  r_mem [MAX_ENTRIES];
    logic [WORD_W-1:0]  r_rd_data;

    logic [NUM_W-1:0]   w_n7;
    logic [CNT_W-1:0]   w_n_eff;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_scan_more;
    logic               w_accept;
    logic               w_load;
    logic               w_mem_we;
    logic [WORD_W-1:0]  w_new_word;

    // Clamp the configured count into 1..MAX_ENTRIES.
    always_comb begin
        if (r_num == '0) begin
            w_n7 = NUM_W'(1);
        end else if (r_num > MAX_NUM) begin
            w_n7 = MAX_NUM;
        end else begin
            w_n7 = r_num;
        end
    end

    assign w_n_eff     = w_n7[CNT_W-1:0];
    assign w_rd_addr   = r_cnt[IDX_W-1:0];
    assign w_scan_more = (r_cnt < w_n_eff);
    assign w_new_word  = make_word(r_id);

    assign i_in_ch.ready       = (r_state == S_IDLE);
    assign w_accept            = i_in_ch.valid && i_in_ch.ready;
    assign w_load              = (r_state == S_FINISH) && (!r_out_vld || o_out_ch.ready);
    assign w_mem_we            = w_load && (r_kind == K_INJECT) && !r_dup && r_found;

    assign o_out_ch.valid      = r_out_vld;
    assign o_out_ch.status     = r_status;
    assign o_out_ch.slot       = r_slot;
    assign o_out_ch.entry_word = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_id      = r_id;
        n_idx_in  = r_idx_in;
        n_cnt     = r_cnt;
        n_cmp_vld = 1'b0;
        n_dup     = r_dup;
        n_found   = r_found;
        n_free_at = r_free_at;
        n_empty   = r_empty;
        n_out_vld = r_out_vld && !o_out_ch.ready;
        n_status  = r_status;
        n_slot    = r_slot;
        n_word    = r_word;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_kind    = t_kind'(i_in_ch.kind);
                    n_id      = i_in_ch.irq_id;
                    n_idx_in  = i_in_ch.entry_index;
                    n_cnt     = '0;
                    n_dup     = 1'b0;
                    n_found   = 1'b0;
                    n_free_at = '0;
                    n_state   = (t_kind'(i_in_ch.kind) == K_INJECT) ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                // Compare the entry read last cycle against the requested id.
                if (r_cmp_vld && (r_rd_data[ID_W-1:0] == r_id)) begin
                    n_dup = 1'b1;
                end
                if (w_scan_more) begin
                    n_cnt     = r_cnt + CNT_W'(1);
                    n_cmp_vld = !r_empty[w_rd_addr];
                    if (r_empty[w_rd_addr] && !r_found) begin
                        n_found   = 1'b1;
                        n_free_at = w_rd_addr;
                    end
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_load) begin
                    n_out_vld = 1'b1;
                    n_status  = ST_OK;
                    n_slot    = '0;
                    n_word    = '0;
                    n_state   = S_IDLE;
                    case (r_kind)
                        K_INJECT: begin
                            if (r_dup) begin
                                n_status = ST_PRESENT;
                            end else if (!r_found) begin
                                n_status = ST_FULL;
                            end else begin
                                n_word             = w_new_word;
                                n_slot             = SLOT_W'(r_free_at);
                                n_empty[r_free_at] = 1'b0;
                            end
                        end
                        K_RETIRE: begin
                            if ({1'b0, r_idx_in} >= w_n7) begin
                                n_status = ST_BADIDX;
                            end else begin
                                n_slot                       = r_idx_in;
                                n_empty[r_idx_in[IDX_W-1:0]] = 1'b1;
                            end
                        end
                        K_CLEAR: begin
                            n_empty = '1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_empty   <= '1;
            r_out_vld <= 1'b0;
            r_num     <= NUM_ENTRIES_RST;
        end else begin
            r_cmp_vld <= n_cmp_vld;
            r_empty   <= n_empty;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_id      <= n_id;
        r_idx_in  <= n_idx_in;
        r_cnt     <= n_cnt;
        r_dup     <= n_dup;
        r_found   <= n_found;
        r_free_at <= n_free_at;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_word    <= n_word;
    end

    // Entry word memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_free_at] <= w_new_word;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cnt <= w_n_eff))
        else $error("scan counter ran past the entry count");

    a_free_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_found) |-> r_empty[r_free_at])
        else $error("chosen free entry is not empty");

    a_inject_occupies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mem_we |=> (!r_empty[$past(r_free_at)] && r_out_vld && (r_status == ST_OK)))
        else $error("injected entry not marked occupied");

endmodule

`default_nettype wire
